// ===== hw/rtl/move_to_front_codec_core_assert.svh =====
// Assertion macros shared by the checker.
`ifndef MOVE_TO_FRONT_CODEC_CORE_ASSERT_SVH
`define MOVE_TO_FRONT_CODEC_CORE_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define MTFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define MTFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset itself.
`define MTFC_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mtfc_pkg.sv =====
`default_nettype none

package mtfc_pkg;

  localparam int ALPHABET     = 256;
  localparam int SYM_W        = 8;
  localparam int CELL_ENTRIES = 8;
  localparam int NUM_CELLS    = (ALPHABET + CELL_ENTRIES - 1) / CELL_ENTRIES;

  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  // Request traveling down the cell row.
  typedef struct packed {
    logic vld;
    logic start;   // list restored to identity as the request passes
    dir_t dir;
    logic shift;   // still moving entries back by one
    logic hit;     // symbol found, front entry to be rewritten
    sym_t sym;
    sym_t carry;   // entry pushed out of the previous position
    sym_t result;
  } wave_t;

endpackage

`default_nettype wire

// ===== hw/rtl/move_to_front_codec_core.sv =====
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+-------------------------------------
// in_      | in  | in_valid/in_stall  | in_symbol_in[7:0], in_block_start
// out_     | out | out_valid/out_stall| out_symbol_out[7:0]
// cfg_     | in  | cfg_wr_en          | cfg_wr_data (0 encode, 1 decode)
//
// One request at a time: it walks the row of NUM_CELLS cells, one cell per
// cycle, and the next one is accepted once the result has been loaded into
// the output register, so the walk and a stalled output both hold it off.
// Reset (rst_n low, synchronous) puts the list in identity order, direction
// back to encode. A stalled result sits in the output register; the next
// request is accepted meanwhile.
`default_nettype none

module move_to_front_codec_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  wire                 cfg_wr_data,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire mtfc_pkg::sym_t in_symbol_in,
  input  wire                 in_block_start,
  output logic                out_valid,
  input  wire                 out_stall,
  output mtfc_pkg::sym_t      out_symbol_out
);

  mtfc_pkg::dir_t  dir_r;
  mtfc_pkg::wave_t wave [mtfc_pkg::NUM_CELLS+1];
  mtfc_pkg::wave_t head_r;
  mtfc_pkg::wave_t head_nxt;
  mtfc_pkg::wave_t tail;

  logic           busy_r;
  logic           done_vld_r;
  mtfc_pkg::sym_t done_sym_r;
  logic           out_valid_r;
  mtfc_pkg::sym_t out_sym_r;

  logic           in_acc;
  logic           out_load;
  logic           in_range;
  logic           front_we;
  mtfc_pkg::sym_t front_sym;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = busy_r;
  // symbols or ranks past the alphabet pass straight through
  assign in_range = ({1'b0, in_symbol_in} < (mtfc_pkg::SYM_W+1)'(mtfc_pkg::ALPHABET));

  // Build the request that enters cell 0.
  always_comb begin
    head_nxt        = head_r;
    head_nxt.vld    = in_acc;
    if (in_acc) begin
      head_nxt.start  = in_block_start;
      head_nxt.dir    = dir_r;
      head_nxt.shift  = in_range;
      head_nxt.hit    = 1'b0;
      head_nxt.sym    = in_symbol_in;
      head_nxt.carry  = in_symbol_in;
      head_nxt.result = in_symbol_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      dir_r  <= mtfc_pkg::DIR_ENCODE;
    end else begin
      head_r <= head_nxt;
      if (cfg_wr_en) begin
        dir_r <= mtfc_pkg::dir_t'(cfg_wr_data);
      end
    end
  end

  assign wave[0] = head_r;

  // Row of cells; each request hops one cell per cycle.
  for (genvar c = 0; c < mtfc_pkg::NUM_CELLS; c++) begin : g_cell
    mtfc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_base (mtfc_pkg::SYM_W'(c * mtfc_pkg::CELL_ENTRIES)),
      .front_we  ((c == 0) ? front_we : 1'b0),
      .front_sym (front_sym),
      .wave_in   (wave[c]),
      .wave_out  (wave[c+1])
    );
  end

  assign tail = wave[mtfc_pkg::NUM_CELLS];

  // The found symbol lands at the front once the request has left the row.
  assign front_we  = tail.vld && tail.hit;
  assign front_sym = (tail.dir == mtfc_pkg::DIR_DECODE) ? tail.result : tail.sym;

  assign out_load = done_vld_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
      if (tail.vld) begin
        done_vld_r <= 1'b1;
      end else if (out_load) begin
        done_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.vld) begin
      done_sym_r <= tail.result;
    end
    if (out_load) begin
      out_sym_r <= done_sym_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_symbol_out = out_sym_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mtfc_cell.sv =====
`default_nettype none

// Holds CELL_ENTRIES consecutive list positions. A request is registered here before it moves on.
module mtfc_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire mtfc_pkg::sym_t cell_base,
  input  wire                 front_we,
  input  wire mtfc_pkg::sym_t front_sym,
  input  wire mtfc_pkg::wave_t wave_in,
  output mtfc_pkg::wave_t     wave_out
);

  mtfc_pkg::sym_t  ent_r   [mtfc_pkg::CELL_ENTRIES];
  mtfc_pkg::sym_t  ent_nxt [mtfc_pkg::CELL_ENTRIES];
  mtfc_pkg::wave_t wave_r;
  mtfc_pkg::wave_t wave_nxt;

  always_comb begin
    mtfc_pkg::sym_t pos;
    mtfc_pkg::sym_t old;
    mtfc_pkg::sym_t upd;
    logic           match;
    wave_nxt = wave_in;
    for (int j = 0; j < mtfc_pkg::CELL_ENTRIES; j++) begin
      pos   = cell_base + mtfc_pkg::SYM_W'(j);
      old   = wave_in.start ? pos : ent_r[j];
      upd   = old;
      match = (wave_nxt.dir == mtfc_pkg::DIR_DECODE) ? (pos == wave_nxt.sym)
                                                     : (old == wave_nxt.sym);
      if (wave_nxt.shift) begin
        // position 0 is rewritten once the request leaves the row
        if (pos != '0) begin
          upd = wave_nxt.carry;
        end
        wave_nxt.carry = old;
        if (match) begin
          wave_nxt.shift  = 1'b0;
          wave_nxt.hit    = 1'b1;
          wave_nxt.result = (wave_nxt.dir == mtfc_pkg::DIR_DECODE) ? old : pos;
        end
      end
      ent_nxt[j] = wave_in.vld ? upd : ent_r[j];
    end
    // found symbol written back to the front
    if (front_we) begin
      ent_nxt[0] = front_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < mtfc_pkg::CELL_ENTRIES; j++) begin
        ent_r[j] <= cell_base + mtfc_pkg::SYM_W'(j);
      end
      wave_r <= '0;
    end else begin
      for (int j = 0; j < mtfc_pkg::CELL_ENTRIES; j++) begin
        ent_r[j] <= ent_nxt[j];
      end
      wave_r <= wave_nxt;
    end
  end

  assign wave_out = wave_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mtfc_checker.sv =====
`default_nettype none

`include "move_to_front_codec_core_assert.svh"

module mtfc_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire mtfc_pkg::sym_t out_symbol_out
);

  logic [1:0] pending_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // requests taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  `MTFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `MTFC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_symbol_out), "stalled result changed")
  `MTFC_ASSERT_NOW(a_no_phantom, out_valid, pending_r != 2'd0, "result with no request")
  `MTFC_ASSERT_NOW(a_bounded, 1'b1, pending_r != 2'd3, "more than two requests outstanding")
  `MTFC_ASSERT_NEXT_RST(a_rst_idle, !rst_n, !out_valid, "result valid after reset")

endmodule

bind move_to_front_codec_core mtfc_checker u_mtfc_checker (.*);

`default_nettype wire

// ===== sim/move_to_front_codec_core_tb.sv =====
`default_nettype none

module move_to_front_codec_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block walks one request down its cell row before it takes the next;
  // REQ_CYCLES sizes the tail wait after the last result.
  localparam int REQ_CYCLES  = mtfc_pkg::NUM_CELLS + 3;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mtfc_pkg::sym_t in_symbol_in = '0;
  logic in_block_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  mtfc_pkg::sym_t out_symbol_out;

  move_to_front_codec_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol_in   (in_symbol_in),
    .in_block_start (in_block_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol_out (out_symbol_out)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the recency list and the direction.
  // ---------------------------------------------------------------------
  mtfc_pkg::sym_t mtf_list [mtfc_pkg::ALPHABET];
  mtfc_pkg::dir_t mtf_dir;

  // Expected output symbols, oldest first.
  mtfc_pkg::sym_t pending_symbols[$];

  int n_sent;
  int n_checked;
  int n_errors;
  int n_encoded;
  int n_decoded;
  int n_restarts;
  int n_cfg_writes;
  int cycle_count;

  // Idle percentages for the sender and the receiver.
  int gap_pct;
  int stall_pct;

  function automatic void mtf_restore();
    for (int i = 0; i < mtfc_pkg::ALPHABET; i++)
      mtf_list[i] = mtfc_pkg::sym_t'(i);
  endfunction

  // Expected result for one request; updates the list as the block would.
  function automatic mtfc_pkg::sym_t mtf_code(mtfc_pkg::sym_t sym, logic start);
    int             pos;
    mtfc_pkg::sym_t res;
    mtfc_pkg::sym_t moved;
    if (start)
      mtf_restore();
    res = sym;
    pos = -1;
    if (int'(sym) < mtfc_pkg::ALPHABET) begin
      if (mtf_dir == mtfc_pkg::DIR_ENCODE) begin
        for (int i = 0; i < mtfc_pkg::ALPHABET; i++)
          if (pos < 0 && mtf_list[i] == sym)
            pos = i;
        if (pos >= 0)
          res = mtfc_pkg::sym_t'(pos);
      end else begin
        pos = int'(sym);
        res = mtf_list[pos];
      end
      // rank zero leaves the list alone
      if (pos > 0) begin
        moved = mtf_list[pos];
        for (int j = pos; j > 0; j--)
          mtf_list[j] = mtf_list[j-1];
        mtf_list[0] = moved;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // Sampled at the rising edge, before the block's own updates land.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with nothing expected", out_symbol_out));
      end else begin
        if (out_symbol_out !== pending_symbols[0])
          report_mismatch($sformatf("result %0d: symbol_out 0x%02h, expected 0x%02h",
                                    n_checked, out_symbol_out, pending_symbols[0]));
        void'(pending_symbols.pop_front());
        n_checked++;
      end
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_symbols.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driving tasks. All of them start and end at a falling edge.
  // ---------------------------------------------------------------------

  // One request. in_valid is left high on return; the next call either
  // reuses it or the caller drops it before the next rising edge.
  task automatic send_request(mtfc_pkg::sym_t sym, logic start);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_symbol_in   = sym;
    in_block_start = start;
    in_valid       = 1'b1;
    do
      @(posedge clk);
    while (in_stall);
    // accepted at this edge: predict now
    pending_symbols = {pending_symbols, mtf_code(sym, start)};
    n_sent++;
    if (start)
      n_restarts++;
    if (mtf_dir == mtfc_pkg::DIR_ENCODE)
      n_encoded++;
    else
      n_decoded++;
    @(negedge clk);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_symbols.size() != 0)
      @(negedge clk);
  endtask

  // Direction write; only called with the block idle.
  task automatic write_direction(mtfc_pkg::dir_t d);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = d;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    mtf_dir   = d;
    n_cfg_writes++;
  endtask

  // Random symbol with locality: mostly near the front of the list.
  function automatic mtfc_pkg::sym_t draw_symbol();
    int r;
    int reach;
    r = $urandom_range(99);
    if (r < 45)
      reach = 7;
    else if (r < 80)
      reach = 31;
    else
      reach = mtfc_pkg::ALPHABET - 1;
    if (mtf_dir == mtfc_pkg::DIR_ENCODE)
      return mtf_list[$urandom_range(reach)];
    return mtfc_pkg::sym_t'($urandom_range(reach));
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Encode: both ends of the byte range, a repeat (rank zero), a restart.
  task automatic test_encode_corners();
    write_direction(mtfc_pkg::DIR_ENCODE);
    send_request(8'd0, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd0, 1'b0);
    send_request(8'd128, 1'b1);
    send_request(8'd128, 1'b0);
    drain_results();
  endtask

  // Decode: first and last rank, rank zero, promotion from the far end.
  task automatic test_decode_corners();
    write_direction(mtfc_pkg::DIR_DECODE);
    send_request(8'd0, 1'b1);
    send_request(8'd255, 1'b0);
    send_request(8'd0, 1'b0);
    send_request(8'd1, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd7, 1'b1);
    drain_results();
  endtask

  // Block start after the list has been shuffled, in both directions.
  task automatic test_block_restart();
    write_direction(mtfc_pkg::DIR_ENCODE);
    send_request(8'd200, 1'b0);
    send_request(8'd200, 1'b1);
    send_request(8'd10, 1'b0);
    drain_results();
    write_direction(mtfc_pkg::DIR_DECODE);
    send_request(8'd3, 1'b1);
    send_request(8'd3, 1'b1);
    drain_results();
  endtask

  // Random stream in chunks; direction flips between chunks while idle.
  task automatic test_random_stream(int n_items, int s_gap, int r_stall);
    int             done;
    int             chunk;
    mtfc_pkg::dir_t d;
    gap_pct   = s_gap;
    stall_pct = r_stall;
    done = 0;
    d = mtfc_pkg::dir_t'($urandom_range(1));
    while (done < n_items) begin
      chunk = $urandom_range(40, 120);
      if (chunk > n_items - done)
        chunk = n_items - done;
      write_direction(d);
      for (int k = 0; k < chunk; k++)
        send_request(draw_symbol(), $urandom_range(99) < 3);
      drain_results();
      done += chunk;
      d = (d == mtfc_pkg::DIR_ENCODE) ? mtfc_pkg::DIR_DECODE : mtfc_pkg::DIR_ENCODE;
    end
  endtask

  initial begin
    mtf_restore();
    mtf_dir   = mtfc_pkg::DIR_ENCODE;
    gap_pct   = 7;
    stall_pct = 72;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_encode_corners();
    test_decode_corners();
    test_block_restart();
    test_random_stream(600, 7, 72);
    test_random_stream(600, 72, 7);
    test_random_stream(600, 0, 0);

    // let any stray result show up before the verdict
    repeat (2 * REQ_CYCLES) @(posedge clk);
    if (pending_symbols.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_symbols.size()));

    $display("covered %0d requests (%0d encode, %0d decode, %0d block starts), %0d cfg writes",
             n_sent, n_encoded, n_decoded, n_restarts, n_cfg_writes);
    $display("checked %0d results in %0d cycles, %0d mismatches",
             n_checked, cycle_count, n_errors);
    if (n_errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mtfc_pkg.sv
hw/rtl/mtfc_cell.sv
hw/rtl/move_to_front_codec_core.sv
hw/rtl/mtfc_checker.sv
sim/move_to_front_codec_core_tb.sv
